// ----- rtl/clen_pkg.sv -----
package clen_pkg;

  // Keyword "content-length:" is fifteen characters long
  localparam int unsigned KEY_LEN = 15;

  typedef enum logic [1:0] {
    KIND_BODY  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_DROP  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STG_SEARCH = 2'd0,
    STG_SPACE  = 2'd1,
    STG_DIGITS = 2'd2,
    STG_DONE   = 2'd3
  } stage_t;

  typedef enum logic [2:0] {
    TERM_NONE   = 3'd0,
    TERM_CR     = 3'd1,
    TERM_CRLF   = 3'd2,
    TERM_LF     = 3'd3,
    TERM_CRLFCR = 3'd4
  } term_t;

  // Header parser state apart from the length value
  typedef struct packed {
    logic [3:0] kw_pos;
    stage_t     stage;
    term_t      term;
  } hdr_state_t;

  // What the parser reports for one header byte
  typedef struct packed {
    logic done;
    logic has_len;
  } hdr_event_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] pos;
  } kw_scan_t;

  localparam hdr_state_t HDR_CLEAR = '{kw_pos: 4'd0, stage: STG_SEARCH, term: TERM_NONE};

  // Keyword character at a given position; positions past the end map to the start
  function automatic logic [7:0] kw_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h63; // c
      4'd1:    ch = 8'h6f; // o
      4'd2:    ch = 8'h6e; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6e; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2d; // -
      4'd8:    ch = 8'h6c; // l
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6e; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      4'd14:   ch = 8'h3a; // :
      default: ch = 8'h63;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b inside {[8'h41:8'h5a]}) r = b + 8'd32;
    return r;
  endfunction

  // Advance the keyword matcher by one lower-cased character
  function automatic kw_scan_t kw_step(input logic [3:0] pos, input logic [7:0] c);
    kw_scan_t   r;
    logic [3:0] p;
    p = (pos < 4'(KEY_LEN)) ? pos : 4'd0;
    r.hit = 1'b0;
    if (c == kw_char(p)) begin
      if (p == 4'(KEY_LEN - 1)) begin
        r.hit = 1'b1;
        r.pos = 4'd0;
      end else begin
        r.pos = p + 4'd1;
      end
    end else begin
      // the first keyword character occurs nowhere else in it
      r.pos = (c == kw_char(4'd0)) ? 4'd1 : 4'd0;
    end
    return r;
  endfunction

endpackage

// ----- rtl/content_length_deframer.sv -----
// Channel  Direction  Ports                                    Moves
// in       input      in_valid, in_ready, in_data_byte         one raw stream byte
// out      output     out_valid, out_ready, out_kind,          body byte, empty frame
//                     out_body_byte, out_last_in_frame         or dropped header
//
// One byte per clock sustained while out_ready is high; not every byte gives a result.
// Every byte is decided combinationally between the input and the result register.
// Synchronous active-low reset clears the parser, the body counter and both valid flags.
// While out_ready is low the result holds, the input register fills, then in_ready drops.
module content_length_deframer
  import clen_pkg::*;
#(
  parameter int LEN_WIDTH = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_body_byte,
  output logic       out_last_in_frame
);

  logic                 in_valid_r;
  logic [7:0]           byte_r;
  logic                 adv;

  hdr_state_t           hdr_r;
  hdr_state_t           hdr_nxt;
  logic [LEN_WIDTH-1:0] len_r;
  logic [LEN_WIDTH-1:0] len_nxt;
  hdr_event_t           evt;

  logic                 in_body_r;
  logic                 in_body_nxt;
  logic [LEN_WIDTH-1:0] rem_r;
  logic [LEN_WIDTH-1:0] rem_nxt;
  logic [LEN_WIDTH-1:0] rem_dec;

  logic                 out_valid_r;
  kind_t                out_kind_r;
  logic [7:0]           out_byte_r;
  logic                 out_last_r;

  logic                 res_valid;
  kind_t                res_kind;
  logic [7:0]           res_byte;
  logic                 res_last;

  // Process the held byte when the result register is free
  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  clen_header #(
    .LEN_WIDTH(LEN_WIDTH)
  ) u_header (
    .data_byte(byte_r),
    .cur      (hdr_r),
    .len_cur  (len_r),
    .nxt      (hdr_nxt),
    .len_nxt  (len_nxt),
    .evt      (evt)
  );

  assign rem_dec = (rem_r != '0) ? rem_r - LEN_WIDTH'(1) : rem_r;

  // Decide the result and the body counter for the held byte
  always_comb begin
    in_body_nxt = in_body_r;
    rem_nxt     = rem_r;
    res_valid   = 1'b0;
    res_kind    = KIND_BODY;
    res_byte    = 8'h00;
    res_last    = 1'b0;
    if (in_body_r) begin
      res_valid = 1'b1;
      res_byte  = byte_r;
      res_last  = (rem_dec == '0);
      rem_nxt   = rem_dec;
      if (rem_dec == '0) in_body_nxt = 1'b0;
    end else if (evt.done) begin
      if (!evt.has_len) begin
        res_valid = 1'b1;
        res_kind  = KIND_DROP;
      end else if (len_nxt == '0) begin
        res_valid = 1'b1;
        res_kind  = KIND_EMPTY;
        res_last  = 1'b1;
      end else begin
        in_body_nxt = 1'b1;
        rem_nxt     = len_nxt;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
    if (in_valid && in_ready) byte_r <= in_data_byte;
  end

  // Parser and body state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r     <= HDR_CLEAR;
      len_r     <= '0;
      in_body_r <= 1'b0;
      rem_r     <= '0;
    end else if (adv) begin
      in_body_r <= in_body_nxt;
      rem_r     <= rem_nxt;
      if (in_body_r || evt.done) begin
        hdr_r <= HDR_CLEAR;
        len_r <= '0;
      end else begin
        hdr_r <= hdr_nxt;
        len_r <= len_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (adv && res_valid) begin
      out_kind_r <= res_kind;
      out_byte_r <= res_byte;
      out_last_r <= res_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_body_byte     = out_byte_r;
  assign out_last_in_frame = out_last_r;

`ifndef SYNTH
  a_body_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_body_r |-> rem_r != '0)
    else $error("body phase with zero bytes remaining");

  a_body_header_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_body_r |-> (hdr_r == HDR_CLEAR) && (len_r == '0))
    else $error("header parser not clear during body");

  a_kw_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_r.kw_pos < 4'(KEY_LEN))
    else $error("keyword position out of range");

  a_non_body_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != KIND_BODY |-> out_byte_r == 8'h00)
    else $error("non-body result carries a byte");

  a_drop_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_DROP |-> !out_last_r)
    else $error("dropped header marked last");
`endif

endmodule

// ----- rtl/clen_header.sv -----
module clen_header
  import clen_pkg::*;
#(
  parameter int LEN_WIDTH = 24
) (
  input  logic [7:0]           data_byte,
  input  hdr_state_t           cur,
  input  logic [LEN_WIDTH-1:0] len_cur,
  output hdr_state_t           nxt,
  output logic [LEN_WIDTH-1:0] len_nxt,
  output hdr_event_t           evt
);

  logic [7:0]           c;
  logic                 is_digit;
  logic                 is_space;
  logic [3:0]           digit;
  logic [LEN_WIDTH+3:0] len_ext;
  logic [LEN_WIDTH+3:0] len_mac;
  kw_scan_t             scan_cont;
  kw_scan_t             scan_fresh;
  hdr_state_t           upd;
  term_t                term_nxt;
  logic                 term_done;

  // Classify the byte
  assign c        = to_lower(data_byte);
  assign is_digit = data_byte inside {[8'h30:8'h39]};
  assign is_space = (data_byte == 8'h20) || (data_byte inside {[8'h09:8'h0d]});
  assign digit    = data_byte[3:0];

  // Multiply by ten and add the digit; four extra bits stop a wrap
  assign len_ext = {4'b0, len_cur};
  assign len_mac = (len_ext << 3) + (len_ext << 1) + {{LEN_WIDTH{1'b0}}, digit};

  assign scan_cont  = kw_step(cur.kw_pos, c);
  assign scan_fresh = kw_step(4'd0, c);

  // Track keyword, whitespace and digits
  always_comb begin
    upd     = cur;
    len_nxt = len_cur;
    case (cur.stage)
      STG_SEARCH: begin
        upd.kw_pos = scan_cont.pos;
        if (scan_cont.hit) upd.stage = STG_SPACE;
      end
      STG_SPACE: begin
        if (is_digit) begin
          len_nxt   = LEN_WIDTH'(digit);
          upd.stage = STG_DIGITS;
        end else if (!is_space) begin
          // restart the search at this byte
          upd.kw_pos = scan_fresh.pos;
          upd.stage  = scan_fresh.hit ? STG_SPACE : STG_SEARCH;
        end
      end
      STG_DIGITS: begin
        if (is_digit) begin
          if (|len_mac[LEN_WIDTH+3:LEN_WIDTH]) len_nxt = '1;
          else len_nxt = len_mac[LEN_WIDTH-1:0];
        end else begin
          upd.stage = STG_DONE;
        end
      end
      default: ;
    endcase
  end

  // Track the blank line that ends the header
  always_comb begin
    term_done = 1'b0;
    term_nxt  = TERM_NONE;
    if (data_byte == 8'h0a) begin
      if (cur.term == TERM_CRLF || cur.term == TERM_LF || cur.term == TERM_CRLFCR) begin
        term_done = 1'b1;
      end else begin
        term_nxt = (cur.term == TERM_CR) ? TERM_CRLF : TERM_LF;
      end
    end else if (data_byte == 8'h0d) begin
      term_nxt = (cur.term == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
    end
  end

  // Report the header event; clear the parser when the header ends
  always_comb begin
    evt.done    = term_done;
    evt.has_len = (upd.stage == STG_DIGITS) || (upd.stage == STG_DONE);
    nxt         = upd;
    nxt.term    = term_nxt;
    if (term_done) nxt = HDR_CLEAR;
  end

endmodule

// ----- tb/deframer_monitor.sv -----
`timescale 1ns / 1ps

// Watch both channels, predict every result from the accepted bytes and
// compare each accepted result with the oldest one still due.
module deframer_monitor
  import clen_pkg::*;
#(
  parameter int LEN_WIDTH = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_kind,
  input  logic [7:0] out_body_byte,
  input  logic       out_last_in_frame,
  output int         fail_count,
  output int         waiting
);

  localparam logic [7:0] CR = 8'h0d;
  localparam logic [7:0] LF = 8'h0a;
  localparam logic [7:0] SP = 8'h20;
  localparam logic [7:0] ZERO_CHAR = 8'h30;
  localparam logic [8*KEY_LEN-1:0] KEY_TEXT = "content-length:";
  localparam logic [LEN_WIDTH-1:0] LEN_MAX = '1;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] body;
    logic       last;
  } frame_out_t;

  frame_out_t           due_results[$];
  frame_out_t           want;

  // Own copy of the deframer state
  logic                 in_frame_body;
  logic [3:0]           key_pos;
  stage_t               stage;
  term_t                term;
  logic [LEN_WIDTH-1:0] length_acc;
  logic [LEN_WIDTH-1:0] body_left;

  initial begin
    fail_count = 0;
    waiting    = 0;
  end

  function automatic logic [7:0] key_char(input logic [3:0] pos);
    return KEY_TEXT[8*(KEY_LEN-1-pos) +: 8];
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= ZERO_CHAR && b <= 8'h39;
  endfunction

  task automatic clear_header();
    key_pos    = 4'd0;
    stage      = STG_SEARCH;
    length_acc = '0;
    term       = TERM_NONE;
  endtask

  // Advance the keyword match by one byte, folding upper case to lower
  task automatic scan_keyword(input logic [7:0] b);
    logic [7:0] c;
    logic [3:0] p;
    c = (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
    p = (key_pos < 4'(KEY_LEN)) ? key_pos : 4'd0;
    if (c == key_char(p)) begin
      p = p + 4'd1;
      if (p == 4'(KEY_LEN)) begin
        stage = STG_SPACE;
        p     = 4'd0;
      end
    end else begin
      // a fresh 'c' can only ever be the start of the keyword
      p = (c == key_char(4'd0)) ? 4'd1 : 4'd0;
    end
    key_pos = p;
  endtask

  // Work out what one accepted stream byte produces
  task automatic deframe_byte(input logic [7:0] b);
    logic [LEN_WIDTH+3:0] wide;
    logic                 blank;
    logic [LEN_WIDTH-1:0] found;

    // body phase: pass every byte, mark the last one
    if (in_frame_body) begin
      if (body_left != '0) body_left = body_left - 1'b1;
      due_results.push_back('{KIND_BODY, b, body_left == '0});
      if (body_left == '0) begin
        in_frame_body = 1'b0;
        clear_header();
      end
      return;
    end

    // length search and collection
    case (stage)
      STG_SEARCH: scan_keyword(b);
      STG_SPACE: begin
        if (is_digit(b)) begin
          length_acc = LEN_WIDTH'(b - ZERO_CHAR);
          stage      = STG_DIGITS;
        end else if (!(b == SP || (b >= 8'h09 && b <= 8'h0d))) begin
          stage   = STG_SEARCH;
          key_pos = 4'd0;
          scan_keyword(b);
        end
      end
      STG_DIGITS: begin
        if (is_digit(b)) begin
          wide = {4'd0, length_acc} * (LEN_WIDTH+4)'(10) + (LEN_WIDTH+4)'(b - ZERO_CHAR);
          length_acc = (wide > {4'd0, LEN_MAX}) ? LEN_MAX : wide[LEN_WIDTH-1:0];
        end else begin
          stage = STG_DONE;
        end
      end
      default: ;
    endcase

    // blank line detection
    blank = 1'b0;
    if (b == LF) begin
      if (term == TERM_CRLF || term == TERM_LF || term == TERM_CRLFCR) blank = 1'b1;
      else term = (term == TERM_CR) ? TERM_CRLF : TERM_LF;
    end else if (b == CR) begin
      term = (term == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
    end else begin
      term = TERM_NONE;
    end
    if (!blank) return;

    // header complete: start a body, report an empty frame or drop it
    if (stage == STG_DIGITS || stage == STG_DONE) begin
      found = length_acc;
      clear_header();
      if (found == '0) begin
        due_results.push_back('{KIND_EMPTY, 8'h00, 1'b1});
      end else begin
        in_frame_body = 1'b1;
        body_left     = found;
      end
    end else begin
      clear_header();
      due_results.push_back('{KIND_DROP, 8'h00, 1'b0});
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_frame_body = 1'b0;
      body_left     = '0;
      clear_header();
      due_results.delete();
    end else begin
      // check the result transaction against the oldest one due
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with nothing due: kind %0d byte %02h last %0b",
                   $time, out_kind, out_body_byte, out_last_in_frame);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (out_kind !== want.kind) begin
            $display("%0t: kind expected %0d, got %0d", $time, want.kind, out_kind);
            fail_count++;
          end
          if (out_body_byte !== want.body) begin
            $display("%0t: body byte expected %02h, got %02h", $time, want.body, out_body_byte);
            fail_count++;
          end
          if (out_last_in_frame !== want.last) begin
            $display("%0t: last flag expected %0b, got %0b", $time, want.last,
                     out_last_in_frame);
            fail_count++;
          end
        end
      end
      // predict from the input transaction
      if (in_valid && in_ready) deframe_byte(in_data_byte);
    end
    waiting = due_results.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import clen_pkg::*;

  localparam int LEN_W = 24;
  localparam logic [7:0] CR  = 8'h0d;
  localparam logic [7:0] LF  = 8'h0a;
  localparam logic [7:0] SP  = 8'h20;
  localparam logic [7:0] TAB = 8'h09;
  localparam logic [7:0] VT  = 8'h0b;
  localparam logic [7:0] FF  = 8'h0c;
  localparam string KEYWORD = "content-length:";

  typedef enum int {
    MSG_PLAIN,
    MSG_RETRY,
    MSG_REPEAT,
    MSG_SPLIT,
    MSG_NOLEN
  } msg_kind_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready    = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_body_byte;
  logic       out_last_in_frame;
  logic       draining     = 1'b0;
  int         fail_count;
  int         waiting;

  int unsigned burst_left = 0;
  int unsigned sent_count = 0;
  logic [7:0]  frame_bytes[$];

  always #1 clk = ~clk;

  content_length_deframer #(.LEN_WIDTH(LEN_W)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_body_byte    (out_body_byte),
    .out_last_in_frame(out_last_in_frame)
  );

  deframer_monitor #(.LEN_WIDTH(LEN_W)) monitor (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_body_byte    (out_body_byte),
    .out_last_in_frame(out_last_in_frame),
    .fail_count       (fail_count),
    .waiting          (waiting)
  );

  // Offer one byte, idling between bursts, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    logic        took;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 48);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    // in_ready is stable at the falling edge, so sample it there
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    burst_left--;
    sent_count++;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    frame_bytes.delete();
  endtask

  // Append text, optionally flipping the case of letters at random
  task automatic push_text(input string s, input bit mix);
    logic [7:0] ch;
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      if (mix && ((ch >= 8'h41 && ch <= 8'h5a) || (ch >= 8'h61 && ch <= 8'h7a)) &&
          $urandom_range(0, 1) == 1)
        ch = ch ^ 8'h20;
      frame_bytes.push_back(ch);
    end
  endtask

  task automatic push_eol();
    if ($urandom_range(0, 1) == 1) frame_bytes.push_back(CR);
    frame_bytes.push_back(LF);
  endtask

  // Whitespace between keyword and digits, now and then across a line end
  task automatic push_gap();
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 3))
        0:       frame_bytes.push_back(SP);
        1:       frame_bytes.push_back(TAB);
        2:       frame_bytes.push_back(VT);
        default: frame_bytes.push_back(FF);
      endcase
    end
    if ($urandom_range(0, 4) == 0) begin
      push_eol();
      frame_bytes.push_back(SP);
    end
  endtask

  // Other header line: never empty, never holding CR or LF
  task automatic push_filler();
    int unsigned r;
    frame_bytes.push_back(8'($urandom_range(8'h41, 8'h5a)));
    repeat ($urandom_range(0, 11)) begin
      r = $urandom_range(0, 9);
      if (r == 0)      frame_bytes.push_back(8'($urandom_range(8'h80, 8'hff)));
      else if (r == 1) frame_bytes.push_back(8'($urandom_range(8'h00, 8'h08)));
      else             frame_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
    end
  endtask

  task automatic push_number(input int unsigned n);
    if ($urandom_range(0, 3) == 0) push_text("00", 0);
    push_text($sformatf("%0d", n), 0);
  endtask

  task automatic push_terminator();
    case ($urandom_range(0, 2))
      0: begin
        frame_bytes.push_back(CR);
        frame_bytes.push_back(LF);
        frame_bytes.push_back(CR);
        frame_bytes.push_back(LF);
      end
      1: begin
        frame_bytes.push_back(LF);
        frame_bytes.push_back(LF);
      end
      default: begin
        frame_bytes.push_back(CR);
        frame_bytes.push_back(LF);
        frame_bytes.push_back(LF);
      end
    endcase
  endtask

  task automatic push_body(input int unsigned n);
    repeat (n) frame_bytes.push_back(8'($urandom));
  endtask

  // Mostly short bodies, some empty, a few long
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 2)  return 0;
    if (r == 2) return $urandom_range(100, 400);
    return $urandom_range(1, 24);
  endfunction

  // Build one header, with its body where it carries a length
  task automatic build_message(input msg_kind_t k);
    int unsigned n;
    n = pick_length();
    repeat ($urandom_range(0, 2)) begin
      push_filler();
      push_eol();
    end
    case (k)
      MSG_PLAIN: begin
        push_text(KEYWORD, 1);
        push_gap();
        push_number(n);
        if ($urandom_range(0, 3) == 0) push_text(";q=1", 0);
      end
      MSG_RETRY: begin
        // keyword with no digits, then a later one that counts
        push_text(KEYWORD, 1);
        push_gap();
        case ($urandom_range(0, 2))
          0: begin
            push_text("none", 1);
            push_eol();
          end
          1: begin
            frame_bytes.push_back(8'($urandom_range(8'h80, 8'hff)));
            push_eol();
          end
          default: ;
        endcase
        push_text(KEYWORD, 1);
        push_gap();
        push_number(n);
      end
      MSG_REPEAT: begin
        push_text(KEYWORD, 1);
        push_gap();
        push_number(n);
        push_eol();
        push_text(KEYWORD, 1);
        push_gap();
        push_number(pick_length());
      end
      MSG_SPLIT: begin
        push_text(($urandom_range(0, 1) == 1) ? "cont" : "content-lengt", 1);
        push_text(KEYWORD, 1);
        push_gap();
        push_number(n);
      end
      default: begin
        case ($urandom_range(0, 2))
          0: begin
            push_text(KEYWORD, 1);
            push_gap();
            push_text("abc", 1);
          end
          1: push_text(KEYWORD, 1);
          default: ;
        endcase
      end
    endcase
    repeat ($urandom_range(0, 2)) begin
      push_eol();
      push_filler();
    end
    push_terminator();
    if (k != MSG_NOLEN) push_body(n);
  endtask

  // Loose bytes, rich in line ends, digits and keyword starts
  task automatic build_noise();
    repeat ($urandom_range(1, 24)) begin
      if ($urandom_range(0, 1) == 1) begin
        frame_bytes.push_back(8'($urandom));
      end else begin
        case ($urandom_range(0, 4))
          0:       frame_bytes.push_back(CR);
          1:       frame_bytes.push_back(LF);
          2:       frame_bytes.push_back(SP);
          3:       frame_bytes.push_back(8'h37);
          default: frame_bytes.push_back(8'h63);
        endcase
      end
    end
  endtask

  // Receiver: own stall pattern, one long hold-off, free flow at the end
  initial begin : receiver
    int unsigned cycles;
    int unsigned mode;
    int unsigned run_left;
    int unsigned hold_left;
    cycles    = 0;
    mode      = 0;
    run_left  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles == 700) hold_left = 400;
      if (run_left == 0) begin
        mode     = $urandom_range(0, 3);
        run_left = $urandom_range(4, 60);
      end
      run_left--;
      if (draining) begin
        out_ready <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= cycles[0];
        endcase
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bare blank lines, empty body, whitespace across a line end
    frame_bytes.push_back(LF);
    frame_bytes.push_back(LF);
    frame_bytes.push_back(CR);
    frame_bytes.push_back(LF);
    frame_bytes.push_back(CR);
    frame_bytes.push_back(LF);
    push_text("Content-Length:0", 0);
    frame_bytes.push_back(CR);
    frame_bytes.push_back(LF);
    frame_bytes.push_back(CR);
    frame_bytes.push_back(LF);
    push_text("CONTENT-LENGTH:", 0);
    frame_bytes.push_back(TAB);
    frame_bytes.push_back(VT);
    frame_bytes.push_back(FF);
    frame_bytes.push_back(CR);
    frame_bytes.push_back(LF);
    push_text(" 2", 0);
    frame_bytes.push_back(LF);
    frame_bytes.push_back(LF);
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'hff);
    send_frame();

    // Random: mostly well-formed messages, some broken ones and noise
    while (sent_count < 1600) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: build_message(MSG_PLAIN);
        5:             build_message(MSG_RETRY);
        6:             build_message(MSG_REPEAT);
        7:             build_message(MSG_SPLIT);
        8:             build_message(MSG_NOLEN);
        default:       build_noise();
      endcase
      send_frame();
    end

    // Saturating length last: its body never completes within the run
    push_text("Content-Length: 99999999999", 0);
    frame_bytes.push_back(CR);
    frame_bytes.push_back(LF);
    frame_bytes.push_back(CR);
    frame_bytes.push_back(LF);
    push_body(30);
    send_frame();

    in_valid <= 1'b0;
    draining <= 1'b1;
    do @(negedge clk); while (waiting != 0);
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Timeout
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
